[rtl/tes_pkg.sv]
`timescale 1ns / 1ps
// tes_pkg: types and constants of the timed event scheduler
// no dependencies; used by the interfaces, the scheduler core and the testbench

package tes_pkg;

	// order stamps
	localparam int ORDER_W = 8;
	localparam int ORDER_SPAN = 256;
	localparam logic [ORDER_W-1:0] ORDER_LAST = 8'd255;
	localparam logic [ORDER_W-1:0] ORDER_SCAN_END = 8'd254;

	// fired events per tick
	localparam int MAX_RESULTS = 32;
	localparam int EMIT_W = 5;
	localparam logic [EMIT_W-1:0] EMIT_LAST = 5'd31;

	// input actions
	localparam logic ACT_ADD = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// result kinds and add status
	localparam logic KIND_ACK = 1'b0;
	localparam logic KIND_FIRED = 1'b1;
	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic        action;
		logic [31:0] event_time;
		logic [15:0] event_token;
		logic [7:0]  listener_id;
	} in_item_t;

	typedef struct packed {
		logic        result_kind;
		logic        add_status;
		logic [31:0] fired_time;
		logic [15:0] fired_token;
		logic [7:0]  fired_listener;
		logic        last_of_run;
	} out_item_t;

	// one table entry as held in the slot memory
	typedef struct packed {
		logic [31:0]        due_time;
		logic [15:0]        token;
		logic [7:0]         listener;
		logic [ORDER_W-1:0] order;
	} slot_entry_t;

	localparam int SLOT_W = $bits(slot_entry_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_FIND,
		ST_REN_MAP,
		ST_REN_FIX,
		ST_ADD_WRITE,
		ST_ACK,
		ST_TICK_SCAN,
		ST_TICK_EMIT
	} sched_state_t;

endpackage

[rtl/tes_if.sv]
`timescale 1ns / 1ps
// tes_in_if, tes_out_if: valid/ready channels of the scheduler
// depends on tes_pkg for the payload types

interface tes_in_if import tes_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tes_out_if import tes_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/tes_ram.sv]
`timescale 1ns / 1ps
// tes_ram: simple dual-port memory, one write and one registered read a cycle
// no dependencies

module tes_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[rtl/timed_event_scheduler_core.sv]
`timescale 1ns / 1ps
// timed_event_scheduler_core: pending event table with ordered firing on ticks
// depends on tes_pkg, tes_in_if, tes_out_if and tes_ram

// The event table lives in a slot memory that is read one entry per cycle.
// An add walks the valid bits to the lowest free slot, writes the entry and
// returns one acknowledgement. Once the order stamp reaches 255 the accepted
// add first compacts the stamps: it builds a rank table over the stamp values
// and then rewrites the slots. A tick scans the whole slot memory through
// the single read port once per fired event, or once when nothing is due,
// and fires at most 32 events. One item is worked on at a time; a finished
// result waits in the output register while the next item is taken. No
// clearing pass follows reset.

module timed_event_scheduler_core import tes_pkg::*; #(
	parameter int CAPACITY = 32
) (
	input logic     clk,
	input logic     arst_n,
	tes_in_if.sink  item,
	tes_out_if.source result
);

	localparam int SW = $clog2(CAPACITY);
	localparam int IW = $clog2(CAPACITY + 2);
	localparam logic [IW-1:0] IDX_LAST = IW'(CAPACITY - 1);
	localparam logic [IW-1:0] IDX_CAP = IW'(CAPACITY);
	localparam logic [IW-1:0] IDX_DRAIN = IW'(CAPACITY + 1);

	sched_state_t state_q, state_d;

	logic [IW-1:0]         idx_q;
	logic [SW-1:0]         idx_slot;
	logic [CAPACITY-1:0]   valid_q;
	logic [ORDER_SPAN-1:0] used_q;
	logic [ORDER_W-1:0]    ins_cnt_q;
	logic [ORDER_W-1:0]    map_v_q;
	logic [ORDER_W-1:0]    rank_q;
	logic [EMIT_W-1:0]     emit_cnt_q;

	logic [31:0]   time_q;
	logic [15:0]   token_q;
	logic [7:0]    lis_q;
	logic [SW-1:0] slot_q;
	logic          full_q;

	logic          found_q, many_q;
	slot_entry_t   best_q;
	logic [SW-1:0] best_idx_q;

	logic          vld_s1, vld_s2;
	logic [SW-1:0] idx_s1, idx_s2;
	slot_entry_t   entry_s1, entry_s2;

	logic      out_valid_q;
	out_item_t out_q;

	logic               item_fire, out_free, cur_valid, used_cur, issue;
	logic               due_s1, better_s1, fired_last, load_ack, load_fired;
	logic               slot_we;
	logic [SW-1:0]      slot_waddr;
	slot_entry_t        slot_wdata;
	logic [SLOT_W-1:0]  slot_rdata;
	logic               map_we;
	logic [ORDER_W-1:0] map_rdata;

	// slot memory and stamp rank table
	tes_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(SLOT_W)
	) u_slot_mem (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (idx_slot),
		.rdata (slot_rdata)
	);

	tes_ram #(
		.DEPTH(ORDER_SPAN),
		.WIDTH(ORDER_W)
	) u_rank_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_v_q),
		.wdata (rank_q),
		.raddr (entry_s1.order),
		.rdata (map_rdata)
	);

	// handshake and scan helpers
	assign item.ready = (state_q == ST_IDLE);
	assign item_fire = item.valid && item.ready;
	assign out_free = !out_valid_q || result.ready;
	assign result.valid = out_valid_q;
	assign result.data = out_q;

	assign idx_slot = idx_q[SW-1:0];
	assign cur_valid = valid_q[idx_slot];
	assign used_cur = used_q[map_v_q];
	assign entry_s1 = slot_entry_t'(slot_rdata);
	assign issue = (state_q == ST_TICK_SCAN || state_q == ST_REN_FIX) && (idx_q < IDX_CAP);

	// earliest due entry, insertion order within one second
	assign due_s1 = vld_s1 && (entry_s1.due_time <= time_q);
	assign better_s1 = !found_q || (entry_s1.due_time < best_q.due_time) ||
		((entry_s1.due_time == best_q.due_time) && (entry_s1.order < best_q.order));
	assign fired_last = !many_q || (emit_cnt_q == EMIT_LAST);

	// next state and memory writes
	always_comb begin
		state_d = state_q;
		load_ack = 1'b0;
		load_fired = 1'b0;
		map_we = 1'b0;
		slot_we = 1'b0;
		slot_waddr = idx_s2;
		slot_wdata = entry_s2;
		case (state_q)
			ST_IDLE: begin
				if (item_fire) begin
					state_d = (item.data.action == ACT_ADD) ? ST_ADD_FIND : ST_TICK_SCAN;
				end
			end
			ST_ADD_FIND: begin
				if (!cur_valid) begin
					state_d = (ins_cnt_q == ORDER_LAST) ? ST_REN_MAP : ST_ADD_WRITE;
				end else if (idx_q == IDX_LAST) begin
					state_d = ST_ACK;
				end
			end
			ST_REN_MAP: begin
				map_we = used_cur;
				if (map_v_q == ORDER_SCAN_END) begin
					state_d = ST_REN_FIX;
				end
			end
			ST_REN_FIX: begin
				slot_we = vld_s2;
				slot_wdata.order = map_rdata;
				if (idx_q == IDX_DRAIN) begin
					state_d = ST_ADD_WRITE;
				end
			end
			ST_ADD_WRITE: begin
				slot_we = 1'b1;
				slot_waddr = slot_q;
				slot_wdata = '{due_time: time_q, token: token_q, listener: lis_q,
					order: ins_cnt_q};
				state_d = ST_ACK;
			end
			ST_ACK: begin
				if (out_free) begin
					load_ack = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_TICK_SCAN: begin
				if (idx_q == IDX_CAP) begin
					state_d = ST_TICK_EMIT;
				end
			end
			ST_TICK_EMIT: begin
				if (!found_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					load_fired = 1'b1;
					state_d = fired_last ? ST_IDLE : ST_TICK_SCAN;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			valid_q <= '0;
			used_q <= '0;
			ins_cnt_q <= '0;
			map_v_q <= '0;
			rank_q <= '0;
			emit_cnt_q <= '0;
			found_q <= 1'b0;
			many_q <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// walk index restarts on every state change
			if (state_d != state_q) begin
				idx_q <= '0;
			end else if (state_q == ST_ADD_FIND || state_q == ST_REN_FIX ||
				state_q == ST_TICK_SCAN) begin
				idx_q <= idx_q + IW'(1);
			end

			// read pipeline flags
			vld_s1 <= issue && cur_valid;
			vld_s2 <= vld_s1 && (state_q == ST_REN_FIX);

			// stamp compaction: rank table over stamp values
			if (state_q != ST_REN_MAP) begin
				map_v_q <= '0;
				rank_q <= '0;
			end else begin
				map_v_q <= map_v_q + 8'd1;
				if (used_cur) begin
					used_q[map_v_q] <= 1'b0;
					used_q[rank_q] <= 1'b1;
					rank_q <= rank_q + 8'd1;
				end
				if (map_v_q == ORDER_SCAN_END) begin
					ins_cnt_q <= used_cur ? rank_q + 8'd1 : rank_q;
				end
			end

			// add commit
			if (state_q == ST_ADD_WRITE) begin
				valid_q[slot_q] <= 1'b1;
				used_q[ins_cnt_q] <= 1'b1;
				ins_cnt_q <= ins_cnt_q + 8'd1;
			end

			// tick search bookkeeping
			if (state_q == ST_IDLE) begin
				emit_cnt_q <= '0;
			end
			if (state_d == ST_TICK_SCAN && state_q != ST_TICK_SCAN) begin
				found_q <= 1'b0;
				many_q <= 1'b0;
			end else if (state_q == ST_TICK_SCAN && due_s1) begin
				found_q <= 1'b1;
				if (found_q) begin
					many_q <= 1'b1;
				end
			end

			// fired event leaves the table
			if (load_fired) begin
				valid_q[best_idx_q] <= 1'b0;
				used_q[best_q.order] <= 1'b0;
				emit_cnt_q <= emit_cnt_q + EMIT_W'(1);
			end

			// output register
			if (load_ack || load_fired) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (item_fire) begin
			time_q <= item.data.event_time;
			token_q <= item.data.event_token;
			lis_q <= item.data.listener_id;
		end

		// free slot or full table
		if (state_q == ST_ADD_FIND) begin
			if (!cur_valid) begin
				slot_q <= idx_slot;
				full_q <= STATUS_OK;
			end else if (idx_q == IDX_LAST) begin
				full_q <= STATUS_FULL;
			end
		end

		idx_s1 <= idx_slot;
		idx_s2 <= idx_s1;
		entry_s2 <= entry_s1;

		if (state_q == ST_TICK_SCAN && due_s1 && better_s1) begin
			best_q <= entry_s1;
			best_idx_q <= idx_s1;
		end

		if (load_ack) begin
			out_q <= '{result_kind: KIND_ACK, add_status: full_q, fired_time: '0,
				fired_token: '0, fired_listener: '0, last_of_run: 1'b1};
		end else if (load_fired) begin
			out_q <= '{result_kind: KIND_FIRED, add_status: STATUS_OK,
				fired_time: best_q.due_time, fired_token: best_q.token,
				fired_listener: best_q.listener, last_of_run: fired_last};
		end
	end

`ifndef SYNTHESIS
	// a fired event always comes from a live slot
	a_fire_from_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load_fired |-> valid_q[best_idx_q])
		else $error("fired event taken from an empty slot");

	// no memory read is in flight while waiting for an item
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!vld_s1 && !vld_s2))
		else $error("read pipeline busy in idle");

	// compaction leaves no more stamps than slots
	a_compact_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REN_FIX) |-> (ins_cnt_q <= ORDER_W'(CAPACITY)))
		else $error("stamp count after compaction exceeds capacity");

	// a tick never fires more than its limit
	a_emit_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(load_fired && emit_cnt_q == EMIT_LAST) |=> (state_q == ST_IDLE))
		else $error("tick fired beyond its result limit");
`endif

endmodule

[tb/tes_sched_checker.sv]
`timescale 1ns / 1ps
// tes_sched_checker: watches both scheduler channels, predicts every result and compares
// depends on tes_pkg and the tes_in_if / tes_out_if interfaces

module tes_sched_checker import tes_pkg::*; #(
	parameter int CAPACITY = 32
) (
	input logic clk,
	input logic arst_n,
	tes_in_if   item_mon,
	tes_out_if  result_mon,
	output int  error_count,
	output int  awaited_count
);

	// shadow copy of the event table
	logic [31:0]        due_sec [CAPACITY];
	logic [15:0]        token_of [CAPACITY];
	logic [7:0]         listener_of [CAPACITY];
	logic [ORDER_W-1:0] stamp_of [CAPACITY];
	logic [CAPACITY-1:0] live;
	logic [ORDER_W-1:0] next_stamp;

	out_item_t awaited_results [$];
	out_item_t want_item;
	int mismatches = 0;
	int awaited_size = 0;

	assign error_count = mismatches;
	assign awaited_count = awaited_size;

	// append one expected result at the tail of the queue
	function automatic void queue_result(out_item_t res);
		awaited_results.insert(awaited_results.size(), res);
	endfunction

	// squeeze the stamps of pending events down to their ranks
	function automatic void compact_stamps();
		logic [ORDER_W-1:0] rank [CAPACITY];
		logic [ORDER_W-1:0] n;
		n = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rank[i] = '0;
			if (live[i]) begin
				n++;
				for (int j = 0; j < CAPACITY; j++)
					if (live[j] && stamp_of[j] < stamp_of[i])
						rank[i]++;
			end
		end
		for (int i = 0; i < CAPACITY; i++)
			if (live[i])
				stamp_of[i] = rank[i];
		next_stamp = n;
	endfunction

	// apply one input transaction to the shadow table and queue what it owes
	function automatic void schedule_step(in_item_t it);
		int slot;
		int best;
		int fired;
		out_item_t res;
		res = '0;
		if (it.action == ACT_ADD) begin
			slot = -1;
			for (int i = 0; i < CAPACITY; i++)
				if (!live[i] && slot < 0)
					slot = i;
			res.result_kind = KIND_ACK;
			res.last_of_run = 1'b1;
			if (slot < 0) begin
				res.add_status = STATUS_FULL;
			end else begin
				if (next_stamp == ORDER_LAST)
					compact_stamps();
				due_sec[slot] = it.event_time;
				token_of[slot] = it.event_token;
				listener_of[slot] = it.listener_id;
				stamp_of[slot] = next_stamp;
				live[slot] = 1'b1;
				next_stamp = next_stamp + ORDER_W'(1);
				res.add_status = STATUS_OK;
			end
			queue_result(res);
		end else begin
			fired = 0;
			best = 0;
			while (fired < MAX_RESULTS && best >= 0) begin
				best = -1;
				for (int i = 0; i < CAPACITY; i++)
					if (live[i] && due_sec[i] <= it.event_time)
						if (best < 0 || due_sec[i] < due_sec[best] ||
							(due_sec[i] == due_sec[best] && stamp_of[i] < stamp_of[best]))
							best = i;
				if (best >= 0) begin
					live[best] = 1'b0;
					res.result_kind = KIND_FIRED;
					res.add_status = STATUS_OK;
					res.fired_time = due_sec[best];
					res.fired_token = token_of[best];
					res.fired_listener = listener_of[best];
					res.last_of_run = 1'b0;
					queue_result(res);
					fired++;
				end
			end
			// flag the final event of this tick
			if (fired > 0) begin
				res.last_of_run = 1'b1;
				awaited_results[awaited_results.size() - 1] = res;
			end
		end
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	// compare results first, then predict from the input taken at the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live = '0;
			next_stamp = '0;
			awaited_results.delete();
			awaited_size = 0;
		end else begin
			if (result_mon.valid === 1'b1 && result_mon.ready === 1'b1) begin
				if (awaited_results.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, actual %h",
						$time, result_mon.data);
				end else begin
					want_item = awaited_results.pop_front();
					check_field("result_kind", 32'(want_item.result_kind),
						32'(result_mon.data.result_kind));
					check_field("add_status", 32'(want_item.add_status),
						32'(result_mon.data.add_status));
					check_field("fired_time", want_item.fired_time,
						result_mon.data.fired_time);
					check_field("fired_token", 32'(want_item.fired_token),
						32'(result_mon.data.fired_token));
					check_field("fired_listener", 32'(want_item.fired_listener),
						32'(result_mon.data.fired_listener));
					check_field("last_of_run", 32'(want_item.last_of_run),
						32'(result_mon.data.last_of_run));
				end
			end
			if (item_mon.valid === 1'b1 && item_mon.ready === 1'b1)
				schedule_step(item_mon.data);
			awaited_size = awaited_results.size();
		end
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// tb: stimulus, handshake pacing and verdict for timed_event_scheduler_core
// depends on tes_pkg, the tes interfaces, the scheduler RTL and tes_sched_checker

module tb import tes_pkg::*; ();

	localparam int CAPACITY = 32;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int HOLD_CYCLES = 600;
	localparam int DRAIN_CYCLES = 120;

	logic clk;
	logic arst_n;
	int errors;
	int awaited;
	int cycles = 0;
	bit steady = 1'b0;
	bit hold_req = 1'b0;
	int items_sent = 0;
	int adds_sent = 0;
	logic [31:0] now_sec = 32'd100;

	tes_in_if item_ch ();
	tes_out_if result_ch ();

	timed_event_scheduler_core #(.CAPACITY(CAPACITY)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	tes_sched_checker #(.CAPACITY(CAPACITY)) u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_mon      (item_ch),
		.result_mon    (result_ch),
		.error_count   (errors),
		.awaited_count (awaited)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic in_item_t make_item(logic act, logic [31:0] t, logic [15:0] tok,
		logic [7:0] lis);
		in_item_t it;
		it.action = act;
		it.event_time = t;
		it.event_token = tok;
		it.listener_id = lis;
		return it;
	endfunction

	// present one transaction, with random idle cycles ahead of it unless steady
	task automatic offer(input in_item_t it);
		if (!steady) begin
			while ($urandom_range(0, 99) < 15) begin
				item_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		item_ch.valid <= 1'b1;
		item_ch.data <= it;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		items_sent++;
		if (it.action == ACT_ADD)
			adds_sent++;
	endtask

	// due second mostly close to now, so that times collide
	function automatic logic [31:0] pick_due();
		int unsigned mode;
		mode = $urandom_range(0, 99);
		if (mode < 6)
			return 32'hFFFF_FFFF;
		if (mode < 10)
			return $urandom();
		if (mode < 16)
			return now_sec - $urandom_range(0, 20);
		return now_sec + $urandom_range(0, 15);
	endfunction

	task automatic add_random();
		offer(make_item(ACT_ADD, pick_due(), 16'($urandom()), 8'($urandom())));
	endtask

	// advance the clock of the scheduler, now and then flush everything
	task automatic tick_random();
		logic [31:0] t;
		if ($urandom_range(0, 99) < 5) begin
			t = 32'hFFFF_FFFF;
		end else begin
			now_sec = now_sec + $urandom_range(0, 25);
			t = now_sec;
		end
		offer(make_item(ACT_TICK, t, 16'($urandom()), 8'($urandom())));
	endtask

	// empty the table, overfill it by one, then fire a full tick
	task automatic fill_table();
		offer(make_item(ACT_TICK, 32'hFFFF_FFFF, 16'($urandom()), 8'($urandom())));
		repeat (CAPACITY + 1)
			offer(make_item(ACT_ADD, now_sec + $urandom_range(0, 6), 16'($urandom()),
				8'($urandom())));
		offer(make_item(ACT_TICK, 32'hFFFF_FFFF, 16'($urandom()), 8'($urandom())));
	endtask

	// result side pacing, with one long hold-off on request
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				result_ch.ready <= steady || ($urandom_range(0, 99) >= 15);
			end
		end
	end

	// stimulus
	initial begin
		bit filled_once;
		bit filled_twice;
		filled_once = 1'b0;
		filled_twice = 1'b0;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty ticks, field extremes, same-second order, partial firing
		offer(make_item(ACT_TICK, 32'd0, 16'hFFFF, 8'hFF));
		offer(make_item(ACT_TICK, 32'hFFFF_FFFF, 16'h0000, 8'h00));
		offer(make_item(ACT_ADD, 32'd0, 16'h0000, 8'h00));
		offer(make_item(ACT_ADD, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF));
		offer(make_item(ACT_ADD, 32'd7, 16'hA5A5, 8'h5A));
		offer(make_item(ACT_ADD, 32'd7, 16'h5A5A, 8'hA5));
		offer(make_item(ACT_ADD, 32'd3, 16'h0001, 8'h01));
		offer(make_item(ACT_TICK, 32'd2, 16'h1234, 8'h12));
		offer(make_item(ACT_TICK, 32'd7, 16'h4321, 8'h21));
		offer(make_item(ACT_TICK, 32'd6, 16'h0F0F, 8'hF0));
		offer(make_item(ACT_TICK, 32'hFFFF_FFFF, 16'hF0F0, 8'h0F));

		// random: bursts of adds closed by a tick, plus noise and two table fills;
		// enough adds to wrap the order stamp with events pending
		while (items_sent < 280 || adds_sent < 275) begin
			steady = (items_sent >= 120 && items_sent < 180);
			if (!filled_once && items_sent >= 60) begin
				hold_req = 1'b1;
				fill_table();
				filled_once = 1'b1;
			end else if (!filled_twice && items_sent >= 200) begin
				item_ch.valid <= 1'b0;
				@(posedge clk);
				wait (awaited == 0);
				fill_table();
				filled_twice = 1'b1;
			end else if ($urandom_range(0, 9) == 0) begin
				offer(make_item(1'($urandom()), $urandom(), 16'($urandom()),
					8'($urandom())));
			end else begin
				repeat ($urandom_range(4, 16))
					add_random();
				tick_random();
			end
		end
		steady = 1'b0;
		item_ch.valid <= 1'b0;

		// drain
		@(posedge clk);
		wait (awaited == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
